// ===== hw/rtl/fir_pkg.sv =====
// Shared constants and controller/datapath interface types for the FIR filter.
// Used by fir_ctrl, fir_dpath and fir_filter_1024_tap.
package fir_pkg;

   localparam int TAPS_DEFAULT = 1024;
   localparam int IDX_W        = 10;
   localparam int DATA_W       = 16;
   localparam int PROD_W       = 32;
   localparam int ACC_W        = 48;

   typedef struct packed {
      logic load;
      logic sample;
      logic issue;
      logic publish;
   } fir_cmd_type;

   typedef struct packed {
      logic last;
      logic pipe_busy;
      logic out_free;
   } fir_status_type;

endpackage

// ===== hw/rtl/fir_filter_1024_tap.sv =====
// Direct-form FIR filter, top level: fir_ctrl sequencer plus fir_dpath MAC datapath; uses fir_pkg.
// Load transaction: one per cycle while no sample is in progress, writes one tap, no response.
// Sample transaction: the single MAC walks TAPS tap/delay pairs, one per cycle; the response is
// registered; no new request is accepted before it is valid, and one can be taken in that same cycle.
// A sample whose predecessor's response is still held waits in its last stage until it is taken.
// Reset: synchronous; a fill count masks the delay line to zero, the tap store is undefined.
module fir_filter_1024_tap
   import fir_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [IDX_W-1:0]         req_tap_index,
   input  logic signed [DATA_W-1:0] req_coefficient,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_trace_start,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ACC_W-1:0]  rsp_filtered
);

   fir_cmd_type    cmd;
   fir_status_type sts;

   fir_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   fir_dpath #(
      .TAPS (TAPS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_tap_index   (req_tap_index),
      .req_coefficient (req_coefficient),
      .req_sample      (req_sample),
      .req_trace_start (req_trace_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered)
   );

   a_no_accept_while_mac: assert property (@(posedge clock) disable iff (reset)
      sts.pipe_busy |-> !req_ready)
      else $error("request accepted while MAC pipeline busy");

   a_publish_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!sts.pipe_busy && sts.out_free && !cmd.issue))
      else $error("result published before accumulation finished");

   a_load_no_response: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_operation) |=> !$rose(rsp_valid))
      else $error("load transaction produced a response");

endmodule

// ===== hw/rtl/fir_ctrl.sv =====
// Sequencer for the FIR filter: handshake on the request side and MAC walk control.
// Depends on fir_pkg for the command and status types.
module fir_ctrl
   import fir_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_operation,
   input  fir_status_type sts,
   output fir_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation) begin
                  cmd.sample = 1'b1;
                  state_in   = ST_RUN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/fir_dpath.sv =====
// Datapath for the FIR filter: tap store, circular delay line, pipelined MAC, result register.
// Depends on fir_pkg for widths and the command and status types.
module fir_dpath
   import fir_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fir_cmd_type              cmd,
   output fir_status_type           sts,
   input  logic [IDX_W-1:0]         req_tap_index,
   input  logic signed [DATA_W-1:0] req_coefficient,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_trace_start,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ACC_W-1:0]  rsp_filtered
);

   localparam int AW       = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FW       = $clog2(TAPS + 1);
   localparam int TAP_SPAN = 1 << IDX_W;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      if (p == AW'(TAPS - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   logic signed [DATA_W-1:0] tap_mem_ff [TAPS];
   logic signed [DATA_W-1:0] dly_mem_ff [TAPS];

   logic [AW-1:0]            wp_ff,   wp_in;
   logic [AW-1:0]            rd_ff,   rd_in;
   logic [AW-1:0]            k_ff,    k_in;
   logic [FW-1:0]            fill_ff, fill_in;
   logic [FW-1:0]            lim_ff;
   logic                     s1_v_ff, s2_v_ff;
   logic                     live_s1_ff;
   logic                     live_now;
   logic signed [DATA_W-1:0] tap_rd_ff;
   logic signed [DATA_W-1:0] dly_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  filtered_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     tap_in_range;

   assign tap_in_range = (32'(req_tap_index) < TAPS);
   assign live_now     = (FW'(k_ff) >= lim_ff) && ((TAPS <= TAP_SPAN) || (32'(k_ff) < TAP_SPAN));

   always_comb begin
      wp_in   = wp_ff;
      rd_in   = rd_ff;
      k_in    = k_ff;
      fill_in = fill_ff;
      if (cmd.sample) begin
         wp_in = wrap_inc(wp_ff);
         rd_in = wrap_inc(wp_ff);
         k_in  = '0;
         if (req_trace_start) begin
            fill_in = FW'(1);
         end else if (fill_ff != FW'(TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.issue) begin
         rd_in = wrap_inc(rd_ff);
         k_in  = k_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && tap_in_range) begin
         tap_mem_ff[AW'(req_tap_index)] <= req_coefficient;
      end
      if (cmd.issue) begin
         tap_rd_ff <= tap_mem_ff[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         dly_mem_ff[wp_ff] <= req_sample;
      end
      if (cmd.issue) begin
         dly_rd_ff <= dly_mem_ff[rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rd_ff        <= '0;
         k_ff         <= '0;
         fill_ff      <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rd_ff        <= rd_in;
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         s1_v_ff      <= cmd.issue;
         s2_v_ff      <= s1_v_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         lim_ff <= FW'(TAPS) - fill_in;
      end
      if (cmd.issue) begin
         live_s1_ff <= live_now;
      end
      if (s1_v_ff) begin
         prod_ff <= live_s1_ff ? PROD_W'(tap_rd_ff) * PROD_W'(dly_rd_ff) : '0;
      end
      if (cmd.sample) begin
         acc_ff <= '0;
      end else if (s2_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.publish) begin
         filtered_ff <= acc_ff;
      end
   end

   assign sts.last      = (k_ff == AW'(TAPS - 1));
   assign sts.pipe_busy = s1_v_ff | s2_v_ff;
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = filtered_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for fir_filter_1024_tap: fills the coefficient store, then runs directed and
// random load/sample transactions under sender idling and receiver stalls.
// Depends on fir_pkg and fir_filter_1024_tap; each output is checked against an in-bench FIR sum.
module testbench
   import fir_pkg::*;
();

   localparam int TAPS         = TAPS_DEFAULT;
   localparam bit OP_LOAD      = 1'b0;
   localparam bit OP_FILTER    = 1'b1;
   localparam int Q15_MAX      = 32767;
   localparam int Q15_MIN      = -32768;
   localparam int RANDOM_ITEMS = 580;
   localparam int HOLD_CYCLES  = 4 * TAPS;
   localparam int CYCLE_LIMIT  = 3_000_000;

   class fir_scoreboard;
      logic signed [DATA_W-1:0] coef_mem [TAPS];
      logic signed [DATA_W-1:0] window [TAPS];
      logic signed [ACC_W-1:0]  expected_filtered [$];
      int fails;
      int loads;
      int samples;
      int checked;

      function new();
         foreach (window[k]) begin
            window[k]   = '0;
            coef_mem[k] = '0;
         end
         fails   = 0;
         loads   = 0;
         samples = 0;
         checked = 0;
      endfunction

      function logic signed [ACC_W-1:0] filter_sample(logic signed [DATA_W-1:0] smp,
                                                      bit start);
         longint acc;
         longint prod;
         if (start) begin
            foreach (window[k]) window[k] = '0;
         end
         for (int k = 0; k < TAPS - 1; k++) window[k] = window[k + 1];
         window[TAPS - 1] = smp;
         acc = 0;
         for (int k = 0; k < TAPS; k++) begin
            prod = coef_mem[k];
            prod = prod * window[k];
            acc += prod;
         end
         return acc[ACC_W-1:0];
      endfunction

      function void note_request(bit op, logic [IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] coef,
                                 logic signed [DATA_W-1:0] smp, bit start);
         if (op == OP_LOAD) begin
            loads++;
            if (idx < TAPS) coef_mem[idx] = coef;
         end else begin
            samples++;
            expected_filtered.push_back(filter_sample(smp, start));
         end
      endfunction

      function int pending();
         return expected_filtered.size();
      endfunction

      task report(string msg);
         fails++;
         $display("mismatch: %s", msg);
      endtask

      task check_response(logic signed [ACC_W-1:0] got);
         logic signed [ACC_W-1:0] want;
         if (expected_filtered.size() == 0) begin
            report($sformatf("output %0d arrived with nothing outstanding", got));
         end else begin
            want = expected_filtered.pop_front();
            checked++;
            if (got !== want)
               report($sformatf("output %0d: filtered %0d, expected %0d", checked, got, want));
         end
      endtask
   endclass

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_operation   = OP_LOAD;
   logic [IDX_W-1:0]         req_tap_index   = '0;
   logic signed [DATA_W-1:0] req_coefficient = '0;
   logic signed [DATA_W-1:0] req_sample      = '0;
   logic                     req_trace_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic signed [ACC_W-1:0]  rsp_filtered;

   fir_scoreboard fir_sb = new();
   int   idle_pct    = 0;
   int   stall_pct   = 0;
   logic hold_off    = 1'b0;
   int   cycle_count = 0;

   fir_filter_1024_tap #(.TAPS(TAPS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_tap_index   (req_tap_index),
      .req_coefficient (req_coefficient),
      .req_sample      (req_sample),
      .req_trace_start (req_trace_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) fir_sb.check_response(rsp_filtered);
      rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_q15();
      int r;
      r = $urandom_range(39);
      case (r)
         0: return Q15_MAX;
         1: return Q15_MIN;
         2: return 0;
         3: return -1;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   task automatic send(bit op, int idx, int coef, int smp, bit start);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_tap_index   <= idx[IDX_W-1:0];
      req_coefficient <= coef[DATA_W-1:0];
      req_sample      <= smp[DATA_W-1:0];
      req_trace_start <= start;
      do @(posedge clock); while (!req_ready);
      fir_sb.note_request(op, idx[IDX_W-1:0], coef[DATA_W-1:0], smp[DATA_W-1:0], start);
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(99);
      if (r < 35)
         send(OP_LOAD, $urandom_range(TAPS - 1), pick_q15(), pick_q15(),
              1'($urandom_range(1)));
      else
         send(OP_FILTER, $urandom_range(TAPS - 1), pick_q15(), pick_q15(),
              $urandom_range(19) == 0);
   endtask

   task automatic hold_receiver(int cycles);
      fork
         begin
            hold_off <= 1'b1;
            repeat (cycles) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill every tap before the first sample reads the store
      for (int i = 0; i < TAPS; i++) send(OP_LOAD, i, pick_q15(), 0, 1'b0);

      send(OP_LOAD, TAPS - 1, Q15_MIN, Q15_MAX, 1'b1);
      send(OP_LOAD, TAPS - 2, Q15_MAX, 0, 1'b0);
      send(OP_LOAD, 0, Q15_MIN, 0, 1'b1);
      send(OP_FILTER, 0, 0, Q15_MAX, 1'b1);
      send(OP_FILTER, TAPS - 1, Q15_MAX, Q15_MIN, 1'b0);
      send(OP_FILTER, 0, Q15_MIN, Q15_MIN, 1'b0);
      send(OP_LOAD, TAPS - 3, 0, Q15_MIN, 1'b0);
      send(OP_FILTER, 0, 0, 0, 1'b0);
      send(OP_FILTER, 0, 0, 1, 1'b1);
      send(OP_FILTER, 0, 0, -1, 1'b0);
      send(OP_LOAD, TAPS - 1, Q15_MAX, 0, 1'b0);
      send(OP_LOAD, TAPS - 2, Q15_MIN, 0, 1'b0);
      send(OP_FILTER, 0, 0, Q15_MAX, 1'b0);
      send(OP_FILTER, 0, 0, Q15_MIN, 1'b1);
      send(OP_FILTER, 0, 0, Q15_MAX, 1'b0);
      send(OP_LOAD, 512, 1, 0, 1'b1);
      send(OP_LOAD, 511, -1, 0, 1'b0);
      send(OP_FILTER, 0, 0, Q15_MIN, 1'b0);
      send(OP_FILTER, 0, 0, Q15_MIN, 1'b0);
      send(OP_FILTER, 0, 0, 12345, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 53;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 53;
               hold_receiver(HOLD_CYCLES);
            end
            default: begin
               idle_pct  = 25;
               stall_pct = 25;
            end
         endcase
         repeat (RANDOM_ITEMS / 4) send_random();
      end
      req_valid <= 1'b0;

      while (fir_sb.pending() != 0) @(posedge clock);
      repeat (TAPS + 64) @(posedge clock);

      $display("Ran %0d coefficient loads and %0d samples through four idle/stall mixes,",
               fir_sb.loads, fir_sb.samples);
      $display("including a long output hold-off; %0d filtered outputs compared, %0d mismatches.",
               fir_sb.checked, fir_sb.fails);
      if (fir_sb.fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== fir_filter_1024_tap.f =====
hw/rtl/fir_pkg.sv
hw/rtl/fir_ctrl.sv
hw/rtl/fir_dpath.sv
hw/rtl/fir_filter_1024_tap.sv
tb/testbench.sv
